@@ design/ftpm_pkg.sv @@
// Shared types and constants for the first-touch page mapper.
`default_nettype none
package ftpm_pkg;

  localparam int unsigned PAGE_BITS  = 10;
  localparam int unsigned NUM_PAGES  = 16384;
  localparam int unsigned VADDR_W    = 24;
  localparam int unsigned PAGE_IDX_W = $clog2(NUM_PAGES);
  localparam int unsigned FRAME_W    = VADDR_W - PAGE_BITS;
  localparam int unsigned CNT_W      = PAGE_IDX_W + 1;
  localparam int unsigned CAP_W      = 15;
  localparam int unsigned OPC_W      = 8;

  localparam logic [CAP_W-1:0] TLB_CAP_RESET = CAP_W'(16384);

  // APB register map
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic        REG_TLB_CAPACITY = 1'b0;  // word index held in paddr[2]

  typedef struct packed {
    logic [OPC_W-1:0]   opcode;
    logic [VADDR_W-1:0] vaddr;
    logic               batch_end;
  } in_beat_t;

  typedef struct packed {
    logic [OPC_W-1:0]   opcode_out;
    logic [VADDR_W-1:0] physical_address;
    logic               newly_mapped;
    logic               copy_failed;
  } out_beat_t;

  // One page table entry
  typedef struct packed {
    logic               mapped;
    logic [FRAME_W-1:0] frame;
  } pte_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_wr;   // write one cleared entry of the clearing pass
    logic load_in;  // capture input beat and start the table read
    logic commit;   // update table and counters, load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;  // clearing pass is at its last entry
    logic out_free;  // result register can take a new beat this cycle
  } sts_t;

endpackage
`default_nettype wire

@@ design/ftpm_ctrl.sv @@
// Sequencer for the page mapper: clearing pass, accept, lookup and commit.
`default_nettype none
module ftpm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire ftpm_pkg::sts_t sts_i,
  output ftpm_pkg::cmd_t     cmd_o,
  output logic               in_stall_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0] state_q, state_d;

  // Commands follow from the state, the input valid and the result register status
  always_comb begin
    cmd_o.clr_wr  = (state_q == ST_CLEAR);
    cmd_o.load_in = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.commit  = (state_q == ST_LOOK) && sts_i.out_free;
    in_stall_o    = (state_q != ST_IDLE);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ design/ftpm_datapath.sv @@
// Page table memory, frame and mapped-page counters, and the result register.
`default_nettype none
module ftpm_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ftpm_pkg::cmd_t                cmd_i,
  output ftpm_pkg::sts_t                     sts_o,
  input  wire ftpm_pkg::in_beat_t            in_data_i,
  input  wire logic [ftpm_pkg::CAP_W-1:0]    tlb_cap_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output ftpm_pkg::out_beat_t                out_data_o
);

  ftpm_pkg::pte_t mem [ftpm_pkg::NUM_PAGES];

  ftpm_pkg::in_beat_t                  in_q;
  ftpm_pkg::pte_t                      rd_q;
  logic [ftpm_pkg::PAGE_IDX_W-1:0]     clr_cnt_q;
  logic [ftpm_pkg::CNT_W-1:0]          next_frame_q;
  logic [ftpm_pkg::CNT_W-1:0]          mapped_cnt_q;
  logic [ftpm_pkg::CNT_W-1:0]          mapped_cnt_d;
  logic                                out_valid_q;
  ftpm_pkg::out_beat_t                 out_q;

  logic [ftpm_pkg::PAGE_IDX_W-1:0]     in_page;
  logic [ftpm_pkg::PAGE_IDX_W-1:0]     cur_page;
  logic                                fresh;
  logic [ftpm_pkg::FRAME_W-1:0]        frame;
  logic                                mem_we;
  logic [ftpm_pkg::PAGE_IDX_W-1:0]     mem_wa;
  ftpm_pkg::pte_t                      mem_wd;

  // Page index: address bits above the offset, wrapped to the table depth
  assign in_page  = in_data_i.vaddr[ftpm_pkg::PAGE_BITS +: ftpm_pkg::PAGE_IDX_W];
  assign cur_page = in_q.vaddr[ftpm_pkg::PAGE_BITS +: ftpm_pkg::PAGE_IDX_W];

  // First touch takes the next free frame
  assign fresh        = !rd_q.mapped;
  assign frame        = fresh ? next_frame_q[ftpm_pkg::FRAME_W-1:0] : rd_q.frame;
  assign mapped_cnt_d = mapped_cnt_q + ftpm_pkg::CNT_W'(fresh);

  // Single write port: clearing pass or new mapping
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_page;
    mem_wd = '{mapped: 1'b1, frame: next_frame_q[ftpm_pkg::FRAME_W-1:0]};
    if (cmd_i.clr_wr) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_q;
      mem_wd = '0;
    end else if (cmd_i.commit && fresh) begin
      mem_we = 1'b1;
    end
  end

  // Table memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd_i.load_in) rd_q <= mem[in_page];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_data_i;
    if (cmd_i.commit) begin
      out_q.opcode_out       <= in_q.opcode;
      out_q.physical_address <= {frame, in_q.vaddr[ftpm_pkg::PAGE_BITS-1:0]};
      out_q.newly_mapped     <= fresh;
      out_q.copy_failed      <= in_q.batch_end &&
                                (mapped_cnt_d > ftpm_pkg::CNT_W'(tlb_cap_i));
    end
  end

  // Control state: clearing counter, frame counter, mapped count, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q    <= '0;
      next_frame_q <= '0;
      mapped_cnt_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cmd_i.commit) begin
        mapped_cnt_q <= mapped_cnt_d;
        if (in_q.batch_end) begin
          next_frame_q <= '0;
        end else if (fresh) begin
          next_frame_q <= next_frame_q + 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == ftpm_pkg::PAGE_IDX_W'(ftpm_pkg::NUM_PAGES - 1));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule
`default_nettype wire

@@ design/first_touch_page_mapper.sv @@
// Top level of the first-touch page mapper: APB register, controller and datapath.
//
//  channel | direction | handshake                    | beat
//  --------+-----------+------------------------------+----------------------------
//  in      | input     | in_valid_i / in_stall_o      | in_data_i  (in_beat_t)
//  out     | output    | out_valid_o / out_stall_i    | out_data_o (out_beat_t)
//  apb     | input     | psel_i, penable_i, pready_o  | paddr_i, pwdata_i, prdata_o
//
// An access accepts the beat and reads the page table, then updates the table and
// loads the result register (registered memory read). After reset a clearing pass
// walks all NUM_PAGES (16384) page table entries, one entry a cycle; in_stall_o
// stays high meanwhile, APB writes still land. A stalled result holds in the
// output register; the next beat is accepted meanwhile and its table update waits
// until the result register frees.
`default_nettype none
module first_touch_page_mapper (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire ftpm_pkg::in_beat_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output ftpm_pkg::out_beat_t                    out_data_o,
  input  wire logic                              psel_i,
  input  wire logic                              penable_i,
  input  wire logic                              pwrite_i,
  input  wire logic [ftpm_pkg::APB_ADDR_W-1:0]   paddr_i,
  input  wire logic [ftpm_pkg::APB_DATA_W-1:0]   pwdata_i,
  output logic [ftpm_pkg::APB_DATA_W-1:0]        prdata_o,
  output logic                                   pready_o
);

  ftpm_pkg::cmd_t               cmd;
  ftpm_pkg::sts_t               sts;
  logic [ftpm_pkg::CAP_W-1:0]   tlb_cap_q;
  logic                         reg_hit;

  // APB register file
  assign pready_o = 1'b1;
  assign reg_hit  = (paddr_i[2] == ftpm_pkg::REG_TLB_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_cap_q <= ftpm_pkg::TLB_CAP_RESET;
    end else if (psel_i && penable_i && pwrite_i && reg_hit) begin
      tlb_cap_q <= pwdata_i[ftpm_pkg::CAP_W-1:0];
    end
  end

  assign prdata_o = reg_hit ? ftpm_pkg::APB_DATA_W'(tlb_cap_q) : '0;

  ftpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  ftpm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .tlb_cap_i   (tlb_cap_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // No beat is taken while the clearing pass runs
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> in_stall_o)
    else $error("input accepted during clearing pass");

  // One access at a time: an accept is never followed by another at once
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second beat accepted during lookup");

  // A result appears only after its lookup cycle
  a_result_after_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && !in_stall_o))
    else $error("result produced without a lookup cycle");

endmodule
`default_nettype wire
